// ===== rtl/two_wire_parity_char_receiver_macros.svh =====
// Assertion macros for the two-wire parity character receiver
`ifndef TWO_WIRE_PARITY_CHAR_RECEIVER_MACROS_SVH
`define TWO_WIRE_PARITY_CHAR_RECEIVER_MACROS_SVH

// same-cycle implication
`define TWPCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TWPCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/twpcr_pkg.sv =====
// Shared types and constants for the two-wire parity character receiver
package twpcr_pkg;

  localparam int unsigned DATA_BITS       = 7;
  localparam int unsigned MAX_MESSAGE_DEF = 64;
  localparam logic [6:0]  THRESH_RESET    = 7'd9;

  typedef enum logic [1:0] {
    KIND_CLK_FALL  = 2'd0,
    KIND_CLK_RISE  = 2'd1,
    KIND_DATA_FALL = 2'd2,
    KIND_DATA_RISE = 2'd3
  } kind_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       char_valid;
    logic [6:0] char_value;
    logic       parity_error;
    logic       message_ready;
    logic [6:0] message_length;
    logic       overflow;
  } res_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  data_level;
  } req_t;

endpackage

// ===== rtl/twpcr_in_stage.sv =====
// Input register stage for edge event requests
module twpcr_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic              in_data_level,
  input  logic              advance,
  output twpcr_pkg::req_t   req
);

  logic                 valid_r;
  twpcr_pkg::kind_t     kind_r;
  logic                 level_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= twpcr_pkg::kind_t'(in_kind);
      level_r <= in_data_level;
    end
  end

  assign req = '{valid: valid_r, kind: kind_r, data_level: level_r};

endmodule

// ===== rtl/twpcr_core.sv =====
// Link state and per-event update logic
`include "two_wire_parity_char_receiver_macros.svh"

module twpcr_core #(
  parameter int unsigned MAX_MESSAGE = twpcr_pkg::MAX_MESSAGE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  twpcr_pkg::req_t   req,
  input  logic [6:0]        threshold,
  output twpcr_pkg::res_t   res
);

  localparam int unsigned CNT_W = $clog2(MAX_MESSAGE + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGE);
  localparam logic [3:0] IDX_PAR  = 4'(twpcr_pkg::DATA_BITS);
  localparam logic [3:0] IDX_DONE = 4'(twpcr_pkg::DATA_BITS + 1);
  localparam logic [2:0] POS_TOP  = 3'(twpcr_pkg::DATA_BITS - 1);

  logic             clock_high_r, clock_high_nxt;
  logic [3:0]       bit_index_r, bit_index_nxt;
  logic [6:0]       shift_bits_r, shift_bits_nxt;
  logic             ones_parity_r, ones_parity_nxt;
  logic             ack_pending_r, ack_pending_nxt;
  logic             ack_good_r, ack_good_nxt;
  logic             line_driven_r, line_driven_nxt;
  logic             driven_value_r, driven_value_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             cvalid, perr, ready, ovf;
  logic [CNT_W-1:0] length;
  logic [CNT_W+6:0] length_ext;

  always_comb begin
    clock_high_nxt   = clock_high_r;
    bit_index_nxt    = bit_index_r;
    shift_bits_nxt   = shift_bits_r;
    ones_parity_nxt  = ones_parity_r;
    ack_pending_nxt  = ack_pending_r;
    ack_good_nxt     = ack_good_r;
    line_driven_nxt  = line_driven_r;
    driven_value_nxt = driven_value_r;
    count_nxt        = count_r;
    cvalid           = 1'b0;
    perr             = 1'b0;
    ready            = 1'b0;
    ovf              = 1'b0;

    unique case (req.kind)
      twpcr_pkg::KIND_CLK_FALL: begin
        clock_high_nxt = 1'b0;
      end
      twpcr_pkg::KIND_CLK_RISE: begin
        clock_high_nxt = 1'b1;
        if (ack_pending_r) begin
          ack_pending_nxt = 1'b0;
          line_driven_nxt = 1'b0;
        end else if (bit_index_r < IDX_PAR) begin
          shift_bits_nxt[POS_TOP - bit_index_r[2:0]] = req.data_level;
          ones_parity_nxt = ones_parity_r ^ req.data_level;
          bit_index_nxt   = bit_index_r + 4'd1;
        end else if (bit_index_r == IDX_PAR) begin
          if (req.data_level == !ones_parity_r) begin
            cvalid = 1'b1;
            if (count_r >= CNT_MAX) begin
              ovf = 1'b1;
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
            ack_good_nxt = 1'b1;
          end else begin
            perr         = 1'b1;
            ack_good_nxt = 1'b0;
          end
          bit_index_nxt = IDX_DONE;
        end
      end
      twpcr_pkg::KIND_DATA_FALL: begin
        if (!clock_high_r) begin
          line_driven_nxt  = 1'b1;
          driven_value_nxt = ack_good_r;
          bit_index_nxt    = 4'd0;
          shift_bits_nxt   = 7'd0;
          ones_parity_nxt  = 1'b0;
          ack_pending_nxt  = 1'b1;
          ack_good_nxt     = 1'b0;
        end
      end
      twpcr_pkg::KIND_DATA_RISE: begin
        if (clock_high_r && bit_index_r == 4'd0 &&
            CMP_W'(count_r) > CMP_W'(threshold)) begin
          ready = 1'b1;
        end
      end
      default: begin
      end
    endcase

    length = count_nxt;
    if (ready) begin
      count_nxt = '0;
    end
  end

  assign length_ext = {7'd0, length};

  assign res = '{
    drive_enable:   line_driven_nxt,
    drive_level:    line_driven_nxt & driven_value_nxt,
    char_valid:     cvalid,
    char_value:     cvalid ? shift_bits_r : 7'd0,
    parity_error:   perr,
    message_ready:  ready,
    message_length: length_ext[6:0],
    overflow:       ovf
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_high_r   <= 1'b0;
      bit_index_r    <= 4'd0;
      shift_bits_r   <= 7'd0;
      ones_parity_r  <= 1'b0;
      ack_pending_r  <= 1'b0;
      ack_good_r     <= 1'b0;
      line_driven_r  <= 1'b0;
      driven_value_r <= 1'b0;
      count_r        <= '0;
    end else if (step) begin
      clock_high_r   <= clock_high_nxt;
      bit_index_r    <= bit_index_nxt;
      shift_bits_r   <= shift_bits_nxt;
      ones_parity_r  <= ones_parity_nxt;
      ack_pending_r  <= ack_pending_nxt;
      ack_good_r     <= ack_good_nxt;
      line_driven_r  <= line_driven_nxt;
      driven_value_r <= driven_value_nxt;
      count_r        <= count_nxt;
    end
  end

  `TWPCR_ASSERT_IMP(a_cnt_bound, 1'b1, count_r <= CNT_MAX, "count above capacity")
  `TWPCR_ASSERT_IMP(a_ovf_full, step && ovf, count_r == CNT_MAX, "overflow below capacity")
  `TWPCR_ASSERT_NXT(a_ready_clr, step && ready, count_r == '0, "count not cleared")
  `TWPCR_ASSERT_NXT(a_char_done, step && (cvalid || perr), bit_index_r == IDX_DONE,
                    "frame not closed after parity")

endmodule

// ===== rtl/twpcr_out_stage.sv =====
// Result register stage
module twpcr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  twpcr_pkg::res_t   res,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output twpcr_pkg::res_t   out_res
);

  logic            valid_r;
  twpcr_pkg::res_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/two_wire_parity_char_receiver.sv =====
// Top level of the two-wire parity character receiver
// Takes one edge event request per cycle while the output is not stalled and
// gives one result per request; a request passes an input register and a
// result register before its result is shown on the out_ ports, and a
// stalled result holds both stages. The sustained rate is one request per
// clock while out_ready is high, set by the per-request state update in the
// core. cfg_wdata sets the ready threshold (reset 9); the user must write it
// only while no request is in flight, as the block does not enforce this.
module two_wire_parity_char_receiver #(
  parameter int unsigned MAX_MESSAGE = twpcr_pkg::MAX_MESSAGE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic       in_data_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_drive_enable,
  output logic       out_drive_level,
  output logic       out_char_valid,
  output logic [6:0] out_char_value,
  output logic       out_parity_error,
  output logic       out_message_ready,
  output logic [6:0] out_message_length,
  output logic       out_overflow
);

  logic [6:0]      threshold_r;
  logic            advance;
  logic            step;
  twpcr_pkg::req_t req;
  twpcr_pkg::res_t res;
  twpcr_pkg::res_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= twpcr_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      threshold_r <= cfg_wdata;
    end
  end

  assign step = req.valid && advance;

  twpcr_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_data_level (in_data_level),
    .advance       (advance),
    .req           (req)
  );

  twpcr_core #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .req       (req),
    .threshold (threshold_r),
    .res       (res)
  );

  twpcr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_drive_enable   = out_res.drive_enable;
  assign out_drive_level    = out_res.drive_level;
  assign out_char_valid     = out_res.char_valid;
  assign out_char_value     = out_res.char_value;
  assign out_parity_error   = out_res.parity_error;
  assign out_message_ready  = out_res.message_ready;
  assign out_message_length = out_res.message_length;
  assign out_overflow       = out_res.overflow;

endmodule
